FILE: hdl/efsd_pkg.sv
// Shared widths, limits and register map for the earliest-free-server dispatcher.
package efsd_pkg;

    localparam int MAX_SERVERS_DEF = 16;

    localparam int ARRIVAL_W = 24;
    localparam int SERVICE_W = 16;
    localparam int SERVER_W  = 4;
    localparam int TICK_W    = 25;
    localparam int SUM_W     = 32;
    localparam int JOBS_W    = 20;
    localparam int NUM_W     = 5;

    localparam int DATA_W    = 32;
    localparam int PADDR_W   = 3;

    localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};
    localparam logic [SUM_W-1:0]  SUM_MAX  = {SUM_W{1'b1}};
    localparam logic [JOBS_W-1:0] JOBS_MAX = {JOBS_W{1'b1}};

    localparam logic [PADDR_W-1:0] REG_NUM_SERVERS = 3'h0;
    localparam logic [NUM_W-1:0]   NUM_SERVERS_RST = 5'd1;

endpackage

FILE: hdl/efsd_if.sv
// Job and result channel interfaces of the dispatcher.
interface efsd_job_if;
    logic                           valid;
    logic                           ready;
    logic [efsd_pkg::ARRIVAL_W-1:0] arrival_time;
    logic [efsd_pkg::SERVICE_W-1:0] service_time;

    modport source (output valid, output arrival_time, output service_time, input ready);
    modport sink   (input valid, input arrival_time, input service_time, output ready);
endinterface

interface efsd_res_if;
    logic                          valid;
    logic                          ready;
    logic [efsd_pkg::SERVER_W-1:0] server_index;
    logic [efsd_pkg::TICK_W-1:0]   wait_time;
    logic [efsd_pkg::TICK_W-1:0]   finish_time;
    logic [efsd_pkg::SUM_W-1:0]    total_wait;
    logic [efsd_pkg::TICK_W-1:0]   max_wait;
    logic [efsd_pkg::TICK_W-1:0]   latest_finish;
    logic [efsd_pkg::JOBS_W-1:0]   job_count;

    modport source (output valid, output server_index, output wait_time, output finish_time,
                    output total_wait, output max_wait, output latest_finish,
                    output job_count, input ready);
    modport sink   (input valid, input server_index, input wait_time, input finish_time,
                    input total_wait, input max_wait, input latest_finish,
                    input job_count, output ready);
endinterface

FILE: hdl/earliest_free_server_dispatch_top.sv
// Earliest-free-server dispatcher: fill, finish-time scan, start/finish and statistics.
// A job that fills an unused server goes straight to the start and finish steps; one
// that scans first has the single comparator read one finish time per cycle over the
// n active servers. A new job is accepted only in the idle step, after the last job's
// result is loaded into the output register; a stalled result holds the finish step.
// Reset (synchronous, active low) clears the sequencer, counters and statistics and sets
// num_servers to 1; finish-time entries are always written before they are scanned.
module earliest_free_server_dispatch_top #(
    parameter int MAX_SERVERS = efsd_pkg::MAX_SERVERS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    efsd_job_if.sink                     i_job,
    efsd_res_if.source                   o_res,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [efsd_pkg::PADDR_W-1:0] paddr,
    input  logic [efsd_pkg::DATA_W-1:0]  pwdata,
    output logic [efsd_pkg::DATA_W-1:0]  prdata,
    output logic                         pready
);

    localparam int IDX_W    = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
    localparam int CNT_W    = $clog2(MAX_SERVERS + 1);
    localparam int ARR_W    = efsd_pkg::ARRIVAL_W;
    localparam int SRV_W    = efsd_pkg::SERVICE_W;
    localparam int SEL_W    = efsd_pkg::SERVER_W;
    localparam int TICK_W   = efsd_pkg::TICK_W;
    localparam int SUM_W    = efsd_pkg::SUM_W;
    localparam int JOBS_W   = efsd_pkg::JOBS_W;
    localparam int NUM_W    = efsd_pkg::NUM_W;
    localparam int DATA_W   = efsd_pkg::DATA_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_START,
        S_FINISH
    } t_state;

    t_state              r_state;
    logic [NUM_W-1:0]    r_num;
    logic [CNT_W-1:0]    r_used;
    logic [CNT_W-1:0]    r_n;
    logic [CNT_W-1:0]    r_ptr;
    logic                r_cmp_vld;
    logic [IDX_W-1:0]    r_cmp_idx;
    logic [IDX_W-1:0]    r_sel;
    logic [TICK_W-1:0]   r_best;
    logic [ARR_W-1:0]    r_arrive;
    logic [SRV_W-1:0]    r_serve;
    logic [TICK_W-1:0]   r_start;
    logic [TICK_W-1:0]   r_wait;
    logic [SUM_W-1:0]    r_wait_sum;
    logic [TICK_W-1:0]   r_wait_peak;
    logic [TICK_W-1:0]   r_fin_peak;
    logic [JOBS_W-1:0]   r_jobs;
    logic                r_out_vld;
    logic [SEL_W-1:0]    r_out_sel;
    logic [TICK_W-1:0]   r_out_wait;
    logic [TICK_W-1:0]   r_out_fin;

    logic [TICK_W-1:0]   r_finish_mem [MAX_SERVERS];
    logic [TICK_W-1:0]   r_rd_data;

    logic [CNT_W-1:0]    w_n;
    logic                w_accept;
    logic                w_cfg_wr;
    logic                w_load;
    logic                w_rd_en;
    logic [TICK_W:0]     w_fin_sum;
    logic [TICK_W-1:0]   w_fin;
    logic [SUM_W:0]      w_sum_ext;
    logic [SUM_W-1:0]    n_wait_sum;
    logic [TICK_W-1:0]   w_arrive_ext;

    always_comb begin
        if (r_num == '0) begin
            w_n = CNT_W'(1);
        end else if (32'(r_num) > 32'(MAX_SERVERS)) begin
            w_n = CNT_W'(MAX_SERVERS);
        end else begin
            w_n = CNT_W'(r_num);
        end
    end

    assign w_accept     = i_job.valid && i_job.ready;
    assign w_cfg_wr     = psel && penable && pwrite && pready;
    assign w_load       = (r_state == S_FINISH) && (!r_out_vld || o_res.ready);
    assign w_rd_en      = (r_state == S_SCAN) && (r_ptr < r_n);
    assign w_arrive_ext = TICK_W'(r_arrive);

    assign w_fin_sum = {1'b0, r_start} + (TICK_W + 1)'(r_serve);
    assign w_fin     = w_fin_sum[TICK_W] ? efsd_pkg::TICK_MAX : w_fin_sum[TICK_W-1:0];

    assign w_sum_ext  = {1'b0, r_wait_sum} + (SUM_W + 1)'(r_wait);
    assign n_wait_sum = w_sum_ext[SUM_W] ? efsd_pkg::SUM_MAX : w_sum_ext[SUM_W-1:0];

    assign i_job.ready = (r_state == S_IDLE);
    assign pready      = 1'b1;
    assign prdata      = (paddr[efsd_pkg::PADDR_W-1:2] ==
                          efsd_pkg::REG_NUM_SERVERS[efsd_pkg::PADDR_W-1:2])
                         ? DATA_W'(r_num) : '0;

    assign o_res.valid         = r_out_vld;
    assign o_res.server_index  = r_out_sel;
    assign o_res.wait_time     = r_out_wait;
    assign o_res.finish_time   = r_out_fin;
    assign o_res.total_wait    = r_wait_sum;
    assign o_res.max_wait      = r_wait_peak;
    assign o_res.latest_finish = r_fin_peak;
    assign o_res.job_count     = r_jobs;

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_finish_mem[r_sel] <= w_fin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_rd_data <= r_finish_mem[r_ptr[IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_num       <= efsd_pkg::NUM_SERVERS_RST;
            r_used      <= '0;
            r_n         <= CNT_W'(1);
            r_ptr       <= '0;
            r_cmp_vld   <= 1'b0;
            r_cmp_idx   <= '0;
            r_sel       <= '0;
            r_best      <= '0;
            r_arrive    <= '0;
            r_serve     <= '0;
            r_start     <= '0;
            r_wait      <= '0;
            r_wait_sum  <= '0;
            r_wait_peak <= '0;
            r_fin_peak  <= '0;
            r_jobs      <= '0;
            r_out_vld   <= 1'b0;
            r_out_sel   <= '0;
            r_out_wait  <= '0;
            r_out_fin   <= '0;
        end else begin
            if (w_cfg_wr && (paddr[efsd_pkg::PADDR_W-1:2] ==
                             efsd_pkg::REG_NUM_SERVERS[efsd_pkg::PADDR_W-1:2])) begin
                r_num <= pwdata[NUM_W-1:0];
            end

            if (o_res.ready && !w_load) begin
                r_out_vld <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_arrive <= i_job.arrival_time;
                        r_serve  <= i_job.service_time;
                        r_n      <= w_n;
                        if (r_used < w_n) begin
                            r_sel   <= r_used[IDX_W-1:0];
                            r_best  <= TICK_W'(i_job.arrival_time);
                            r_used  <= r_used + CNT_W'(1);
                            r_state <= S_START;
                        end else begin
                            r_ptr     <= '0;
                            r_cmp_vld <= 1'b0;
                            r_state   <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (r_ptr < r_n) begin
                        r_ptr     <= r_ptr + CNT_W'(1);
                        r_cmp_vld <= 1'b1;
                        r_cmp_idx <= r_ptr[IDX_W-1:0];
                    end else begin
                        r_cmp_vld <= 1'b0;
                    end
                    if (r_cmp_vld && ((r_cmp_idx == '0) || (r_rd_data < r_best))) begin
                        r_best <= r_rd_data;
                        r_sel  <= r_cmp_idx;
                    end
                    if (r_cmp_vld && (r_ptr == r_n)) begin
                        r_state <= S_START;
                    end
                end
                S_START: begin
                    if (r_best >= w_arrive_ext) begin
                        r_start <= r_best;
                        r_wait  <= r_best - w_arrive_ext;
                    end else begin
                        r_start <= w_arrive_ext;
                        r_wait  <= '0;
                    end
                    r_state <= S_FINISH;
                end
                S_FINISH: begin
                    if (w_load) begin
                        r_out_vld  <= 1'b1;
                        r_out_sel  <= SEL_W'(r_sel);
                        r_out_wait <= r_wait;
                        r_out_fin  <= w_fin;
                        r_wait_sum <= n_wait_sum;
                        if (r_wait > r_wait_peak) begin
                            r_wait_peak <= r_wait;
                        end
                        if (w_fin > r_fin_peak) begin
                            r_fin_peak <= w_fin;
                        end
                        if (r_jobs != efsd_pkg::JOBS_MAX) begin
                            r_jobs <= r_jobs + JOBS_W'(1);
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_used) <= 32'(MAX_SERVERS))
        else $error("filled server count exceeds server limit");

    a_sel_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_START) |-> (CNT_W'(r_sel) < r_n))
        else $error("selected server outside active range");

    a_out_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> $past(r_state == S_FINISH))
        else $error("result raised outside finish step");

    a_sum_monotone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_wait_sum >= $past(r_wait_sum)) && (r_jobs >= $past(r_jobs)))
        else $error("running totals decreased");

endmodule
